// ----- src/common_neighbour_strengthen_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the common-neighbor strengthening core
// Concurrent checks that compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef COMMON_NEIGHBOUR_STRENGTHEN_CORE_DEFINES_SVH
`define COMMON_NEIGHBOUR_STRENGTHEN_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CNS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);
// next-cycle implication, consequent may carry a constant delay
`define CNS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);
`else
`define CNS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CNS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/cns_pkg.sv -----
// ----------------------------------------------------------------------------
// cns_pkg
// Shared widths, request codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package cns_pkg;

    // default node count of the matrix
    localparam int MAX_NODES_DEF = 64;

    // field widths
    localparam int IDX_W = 6;
    localparam int VAL_W = 8;
    localparam int RES_W = 9;

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic clear_en;
        logic read_en;
        logic write_en;
        logic count_en;
        logic sum_en;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic is_query;
    } t_status;

endpackage

// ----- src/cns_ctrl.sv -----
// ----------------------------------------------------------------------------
// cns_ctrl
// Sequencer: clearing sweep after reset, then read / write or count / sum.
// ----------------------------------------------------------------------------
module cns_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  cns_pkg::t_status i_status,
    output cns_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_WRITE = 6'b001000,
        S_COUNT = 6'b010000,
        S_SUM   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read_en = 1'b1;
                n_state = i_status.is_query ? S_COUNT : S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write_en = 1'b1;
                n_state        = S_IDLE;
            end
            S_COUNT: begin
                o_cmd.count_en = 1'b1;
                n_state        = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ----- src/cns_datapath.sv -----
// ----------------------------------------------------------------------------
// cns_datapath
// Entry store, unit-weight column vectors, lane popcount and result sum.
// ----------------------------------------------------------------------------
module cns_datapath #(
    parameter int MAX_NODES = cns_pkg::MAX_NODES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cns_pkg::t_cmd             i_cmd,
    output cns_pkg::t_status          o_status,
    input  logic                      i_req_type,
    input  logic [cns_pkg::IDX_W-1:0] i_row_index,
    input  logic [cns_pkg::IDX_W-1:0] i_col_index,
    input  logic [cns_pkg::VAL_W-1:0] i_entry_value,
    output logic                      o_result_strobe,
    output logic [cns_pkg::RES_W-1:0] o_result_value
);

    // only nodes reachable by the index fields get storage
    localparam int IDX_SPAN = 1 << cns_pkg::IDX_W;
    localparam int NODES    = (MAX_NODES < IDX_SPAN) ? MAX_NODES : IDX_SPAN;
    localparam int DEPTH    = NODES * NODES;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int COL_W    = $clog2(NODES);
    localparam int LANES    = (NODES + 7) / 8;
    localparam int LANE_W   = 4;

    // storage
    logic [cns_pkg::VAL_W-1:0] entry_mem [DEPTH];
    logic [NODES-1:0]          col_mem   [NODES];

    // captured request
    logic                      r_req;
    logic [cns_pkg::IDX_W-1:0] r_row;
    logic [cns_pkg::IDX_W-1:0] r_col;
    logic [cns_pkg::VAL_W-1:0] r_val;

    // read data and pipeline registers
    logic [cns_pkg::VAL_W-1:0] r_entry;
    logic [NODES-1:0]          r_vec_r;
    logic [NODES-1:0]          r_vec_c;
    logic [LANE_W-1:0]         r_lane [LANES];
    logic [ADDR_W-1:0]         r_clr_cnt;
    logic                      r_strobe;
    logic [cns_pkg::RES_W-1:0] r_result;

    logic                      w_in_range;
    logic [COL_W-1:0]          w_row;
    logic [COL_W-1:0]          w_col;
    logic [ADDR_W-1:0]         w_addr;
    logic [NODES-1:0]          w_vec_upd;
    logic [LANES*8-1:0]        w_and;
    logic [cns_pkg::RES_W-1:0] w_sum;

    // capture the request beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req_type;
            r_row <= i_row_index;
            r_col <= i_col_index;
            r_val <= i_entry_value;
        end
    end

    // address decode; out-of-range requests fall back to node zero
    assign w_in_range = ((cns_pkg::IDX_W + 1)'(r_row) < (cns_pkg::IDX_W + 1)'(NODES)) &&
                        ((cns_pkg::IDX_W + 1)'(r_col) < (cns_pkg::IDX_W + 1)'(NODES));
    assign w_row  = w_in_range ? r_row[COL_W-1:0] : '0;
    assign w_col  = w_in_range ? r_col[COL_W-1:0] : '0;
    assign w_addr = ADDR_W'(w_row) * ADDR_W'(NODES) + ADDR_W'(w_col);

    // set or drop this row's bit in the column vector
    always_comb begin
        w_vec_upd        = r_vec_c;
        w_vec_upd[w_row] = (r_val == cns_pkg::VAL_W'(1));
    end

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_en && (r_clr_cnt != ADDR_W'(DEPTH - 1))) begin
            r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
        end
    end

    // entry store: clear, write, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            entry_mem[r_clr_cnt] <= '0;
        end else if (i_cmd.write_en && w_in_range) begin
            entry_mem[w_addr] <= r_val;
        end
        if (i_cmd.read_en) begin
            r_entry <= entry_mem[w_addr];
        end
    end

    // column vectors: clear, write, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            if (r_clr_cnt < ADDR_W'(NODES)) begin
                col_mem[r_clr_cnt[COL_W-1:0]] <= '0;
            end
        end else if (i_cmd.write_en && w_in_range) begin
            col_mem[w_col] <= w_vec_upd;
        end
        if (i_cmd.read_en) begin
            r_vec_r <= col_mem[w_row];
            r_vec_c <= col_mem[w_col];
        end
    end

    // count shared unit neighbors per byte lane
    assign w_and = (LANES * 8)'(r_vec_r & r_vec_c);

    always_ff @(posedge i_clk) begin
        if (i_cmd.count_en) begin
            for (int k = 0; k < LANES; k++) begin
                logic [LANE_W-1:0] cnt;
                cnt = '0;
                for (int b = 0; b < 8; b++) begin
                    cnt = cnt + LANE_W'(w_and[k*8 + b]);
                end
                r_lane[k] <= cnt;
            end
        end
    end

    // add lane counts to the entry, off the diagonal only
    always_comb begin
        w_sum = cns_pkg::RES_W'(r_entry);
        if (r_row != r_col) begin
            for (int k = 0; k < LANES; k++) begin
                w_sum = w_sum + cns_pkg::RES_W'(r_lane[k]);
            end
        end
        if (!w_in_range) begin
            w_sum = '0;
        end
    end

    // result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.sum_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_en) begin
            r_result <= w_sum;
        end
    end

    assign o_status.clear_done = (r_clr_cnt == ADDR_W'(DEPTH - 1));
    assign o_status.is_query   = (r_req == cns_pkg::REQ_QUERY);
    assign o_result_strobe     = r_strobe;
    assign o_result_value      = r_result;

endmodule

// ----- src/common_neighbour_strengthen_core.sv -----
// ----------------------------------------------------------------------------
// common_neighbour_strengthen_core
// Adjacency matrix with common-neighbor strengthened queries.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  request   | start / busy           | i_req_type, i_row_index, i_col_index,
//            |                        | i_entry_value
//  result    | o_result_strobe        | o_result_value
//
//  A load goes from accept through a read, then a read-modify-write of one
//  column vector and the entry store, before the next accept.
//  A query steps through memory read, byte-lane popcount and sum; the result
//  strobe comes on the cycle busy drops.
//  After reset busy stays high while a sweep clears the entry store
//  (MAX_NODES*MAX_NODES entries, capped at 64*64) and the column vectors.
//  The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`include "common_neighbour_strengthen_core_defines.svh"

module common_neighbour_strengthen_core #(
    parameter int MAX_NODES = cns_pkg::MAX_NODES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_req_type,
    input  logic [cns_pkg::IDX_W-1:0] i_row_index,
    input  logic [cns_pkg::IDX_W-1:0] i_col_index,
    input  logic [cns_pkg::VAL_W-1:0] i_entry_value,
    output logic                      o_result_strobe,
    output logic [cns_pkg::RES_W-1:0] o_result_value
);

    cns_pkg::t_cmd    cmd;
    cns_pkg::t_status status;

    cns_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cns_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_req_type      (i_req_type),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_entry_value   (i_entry_value),
        .o_result_strobe (o_result_strobe),
        .o_result_value  (o_result_value)
    );

    // a result beat only appears once the sequencer is back to idle
    `CNS_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_result_strobe, !busy, "strobe while busy")

    // an accepted query delivers its result after the read, count and sum states
    `CNS_ASSERT_NXT(a_query_result, i_clk, i_rst_n, start && !busy && (i_req_type == cns_pkg::REQ_QUERY), ##3 o_result_strobe, "query result missing")

    // an accepted load reaches its write cycle
    `CNS_ASSERT_NXT(a_load_write, i_clk, i_rst_n, start && !busy && (i_req_type == cns_pkg::REQ_LOAD), ##1 cmd.write_en, "load write missing")

endmodule

// ----- bench/cns_strength_checker.sv -----
// ----------------------------------------------------------------------------
// cns_strength_checker
// Watches the request and result channels of the common-neighbor core. It
// keeps its own copy of the adjacency matrix and the unit-weight column
// vectors, predicts each strengthened value when a query beat is accepted,
// and compares it with the next result beat.
// ----------------------------------------------------------------------------
module cns_strength_checker
    import cns_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic             i_req_type,
    input  logic [IDX_W-1:0] i_row_index,
    input  logic [IDX_W-1:0] i_col_index,
    input  logic [VAL_W-1:0] i_entry_value,
    input  logic             i_result_strobe,
    input  logic [RES_W-1:0] i_result_value,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES   = MAX_NODES_DEF;
    localparam int RES_SAT = (1 << RES_W) - 1;

    logic [VAL_W-1:0] weight_matrix [NODES][NODES];
    logic [NODES-1:0] unit_columns  [NODES];
    logic [RES_W-1:0] pending_values [$];
    int               mismatch_total;
    int               checked_total;

    // stored weight plus shared unit-weight neighbors off the diagonal
    function automatic logic [RES_W-1:0] strengthened_value(
        input logic [IDX_W-1:0] row,
        input logic [IDX_W-1:0] col
    );
        int unsigned total;
        total = 32'(weight_matrix[row][col]);
        if (row != col)
            total += $countones(unit_columns[row] & unit_columns[col]);
        if (total > RES_SAT)
            total = RES_SAT;
        return total[RES_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [RES_W-1:0] want;
        if (!i_rst_n) begin
            // clear the matrix copy and drop anything outstanding
            for (int r = 0; r < NODES; r++) begin
                unit_columns[r] = '0;
                for (int c = 0; c < NODES; c++)
                    weight_matrix[r][c] = '0;
            end
            pending_values.delete();
            mismatch_total = 0;
            checked_total  = 0;
        end else begin
            // compare a result beat with the oldest prediction
            if (i_result_strobe) begin
                if (pending_values.size() == 0) begin
                    mismatch_total++;
                    $display("%0t ns: unexpected result beat, expected none, actual %0d",
                             $time, i_result_value);
                end else begin
                    want = pending_values.pop_front();
                    checked_total++;
                    if (i_result_value !== want) begin
                        mismatch_total++;
                        $display("%0t ns: result_value mismatch, expected %0d, actual %0d",
                                 $time, want, i_result_value);
                    end
                end
            end

            // apply an accepted request beat
            if (i_start && !i_busy) begin
                if (i_req_type == REQ_QUERY) begin
                    want = strengthened_value(i_row_index, i_col_index);
                    pending_values.insert(pending_values.size(), want);
                end else begin
                    weight_matrix[i_row_index][i_col_index] = i_entry_value;
                    unit_columns[i_col_index][i_row_index]  = (i_entry_value == 8'd1);
                end
            end
        end
        o_fail_count    <= mismatch_total;
        o_checked_count <= checked_total;
        o_pending       <= pending_values.size();
    end

endmodule

// ----- bench/common_neighbour_strengthen_core_tb.sv -----
// ----------------------------------------------------------------------------
// common_neighbour_strengthen_core_tb
// Drives load and query beats into the common-neighbor core in random bursts,
// first a directed set around the diagonal, unit weights and field extremes,
// then random traffic concentrated on a few nodes so that shared neighbors
// build up. The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module common_neighbour_strengthen_core_tb;
    import cns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_TARGET = 1450;
    localparam int DRAIN_LIMIT   = 500;
    localparam int SETTLE_CYCLES = 8;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             i_req_type = REQ_LOAD;
    logic [IDX_W-1:0] i_row_index = '0;
    logic [IDX_W-1:0] i_col_index = '0;
    logic [VAL_W-1:0] i_entry_value = '0;
    logic             o_result_strobe;
    logic [RES_W-1:0] o_result_value;

    int fail_count;
    int pending_count;
    int checked_count;
    int loads_sent;
    int queries_sent;

    common_neighbour_strengthen_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_entry_value   (i_entry_value),
        .o_result_strobe (o_result_strobe),
        .o_result_value  (o_result_value)
    );

    cns_strength_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_req_type      (i_req_type),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_entry_value   (i_entry_value),
        .i_result_strobe (o_result_strobe),
        .i_result_value  (o_result_value),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count),
        .o_checked_count (checked_count)
    );

    always #5 i_clk = ~i_clk;

    // hard stop in case the core hangs
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // present one request beat and hold it until the core takes it
    task automatic send_request(
        input logic             kind,
        input logic [IDX_W-1:0] row,
        input logic [IDX_W-1:0] col,
        input logic [VAL_W-1:0] value
    );
        @(negedge i_clk);
        start         = 1'b1;
        i_req_type    = kind;
        i_row_index   = row;
        i_col_index   = col;
        i_entry_value = value;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        if (kind == REQ_QUERY)
            queries_sent++;
        else
            loads_sent++;
    endtask

    // drop start for a few cycles with noise on the payload
    task automatic idle_gap(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start         = 1'b0;
            i_req_type    = ($urandom_range(0, 1) != 0) ? REQ_QUERY : REQ_LOAD;
            i_row_index   = IDX_W'($urandom_range(0, 63));
            i_col_index   = IDX_W'($urandom_range(0, 63));
            i_entry_value = VAL_W'($urandom_range(0, 255));
        end
    endtask

    // mostly a dozen hot nodes, sometimes anywhere in the matrix
    function automatic logic [IDX_W-1:0] pick_node();
        logic [IDX_W-1:0] node;
        if ($urandom_range(0, 3) != 0)
            node = IDX_W'($urandom_range(0, 11));
        else
            node = IDX_W'($urandom_range(0, 63));
        return node;
    endfunction

    task automatic send_random_request();
        logic             kind;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
        int               roll;
        kind = ($urandom_range(0, 1) != 0) ? REQ_QUERY : REQ_LOAD;
        row  = pick_node();
        col  = pick_node();
        if (kind == REQ_QUERY && $urandom_range(0, 9) == 0)
            col = row;
        // favor unit weights so column vectors fill up
        roll = $urandom_range(0, 9);
        if (roll < 4)
            value = 8'd1;
        else if (roll == 4)
            value = 8'd0;
        else
            value = VAL_W'($urandom_range(0, 255));
        send_request(kind, row, col, value);
    endtask

    initial begin
        int burst;
        int drain;

        loads_sent   = 0;
        queries_sent = 0;

        // hold reset, then release away from the rising edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // never-loaded entries, diagonal and off-diagonal
        send_request(REQ_QUERY, 6'd0, 6'd0, 8'd0);
        send_request(REQ_QUERY, 6'd63, 6'd0, 8'd255);
        // maximum weight on the far diagonal
        send_request(REQ_LOAD, 6'd63, 6'd63, 8'd255);
        send_request(REQ_QUERY, 6'd63, 6'd63, 8'd0);
        // two shared unit-weight neighbors of columns 40 and 41
        send_request(REQ_LOAD, 6'd3, 6'd40, 8'd1);
        send_request(REQ_LOAD, 6'd3, 6'd41, 8'd1);
        send_request(REQ_LOAD, 6'd63, 6'd40, 8'd1);
        send_request(REQ_LOAD, 6'd63, 6'd41, 8'd1);
        send_request(REQ_LOAD, 6'd40, 6'd41, 8'd254);
        send_request(REQ_QUERY, 6'd40, 6'd41, 8'd0);
        send_request(REQ_QUERY, 6'd41, 6'd40, 8'd0);
        // unit weight on the diagonal adds nothing to the diagonal query
        send_request(REQ_LOAD, 6'd40, 6'd40, 8'd1);
        send_request(REQ_QUERY, 6'd40, 6'd40, 8'd0);
        // overwrite one unit entry with a heavier weight and another with zero
        send_request(REQ_LOAD, 6'd3, 6'd41, 8'd2);
        send_request(REQ_QUERY, 6'd40, 6'd41, 8'd0);
        send_request(REQ_LOAD, 6'd63, 6'd40, 8'd0);
        send_request(REQ_QUERY, 6'd41, 6'd40, 8'd0);
        // corner entries
        send_request(REQ_LOAD, 6'd0, 6'd63, 8'd128);
        send_request(REQ_QUERY, 6'd0, 6'd63, 8'd0);
        send_request(REQ_QUERY, 6'd63, 6'd0, 8'd0);
        idle_gap(3);

        // random traffic in bursts, some with no gap at all
        while (loads_sent + queries_sent < RANDOM_TARGET) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 12);
            repeat (burst)
                send_random_request();
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 6));
        end
        idle_gap(1);

        // wait for every predicted result, then let the pipeline settle
        for (drain = 0; drain < DRAIN_LIMIT && pending_count != 0; drain++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d loads and %0d queries in random bursts and gaps.",
                 loads_sent, queries_sent);
        $display("Checked %0d strengthened values, %0d still outstanding.",
                 checked_count, pending_count);
        if (fail_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
